@@ rtl/mts_pkg.sv @@
// Shared types, character codes and entity tables for the markup text stripper.
// No dependencies; used by every module of the block.
package mts_pkg;

  localparam int MaxResults  = 6;
  localparam int HeldDepth   = 4;
  localparam int NumEntities = 6;
  localparam int EntMaxLen   = 5;

  typedef logic [7:0] byte_t;

  // character codes
  localparam byte_t ChLt    = 8'h3C;
  localparam byte_t ChGt    = 8'h3E;
  localparam byte_t ChAmp   = 8'h26;
  localparam byte_t ChSlash = 8'h2F;
  localparam byte_t ChCr    = 8'h0D;
  localparam byte_t ChLf    = 8'h0A;
  localparam byte_t ChSp    = 8'h20;
  localparam byte_t ChTab   = 8'h09;
  localparam byte_t ChVt    = 8'h0B;
  localparam byte_t ChFf    = 8'h0C;

  // one front-to-back request: the result bytes that one input byte causes
  typedef struct packed {
    logic [MaxResults-1:0][7:0] chars;
    logic [2:0]                 count;
    logic                       eot;
  } job_t;

  // entity body after '&', left-justified, one character per byte
  function automatic logic [8*EntMaxLen-1:0] ent_text(input int k);
    logic [8*EntMaxLen-1:0] t;
    case (k)
      0:       t = {"amp;", 8'h00};
      1:       t = {"lt;", 16'h0000};
      2:       t = {"gt;", 16'h0000};
      3:       t = "quot;";
      4:       t = "apos;";
      5:       t = "nbsp;";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] ent_len(input int k);
    logic [2:0] l;
    case (k)
      0:       l = 3'd4;
      1:       l = 3'd3;
      2:       l = 3'd3;
      3:       l = 3'd5;
      4:       l = 3'd5;
      5:       l = 3'd5;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic byte_t ent_value(input int k);
    byte_t v;
    case (k)
      0:       v = 8'h26;
      1:       v = 8'h3C;
      2:       v = 8'h3E;
      3:       v = 8'h22;
      4:       v = 8'h27;
      5:       v = 8'h20;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/mts_front.sv @@
// Front end: accepts markup bytes, tracks tag/entity/white-space state and
// packs the result bytes of each input byte into one request. Uses mts_pkg.
module mts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_text_i,
  output logic               full_o,
  input  logic               job_full_i,
  output logic               job_push_o,
  output mts_pkg::job_t      job_o
);

  typedef enum logic [1:0] {
    PhaseIdle,
    PhaseSkip,
    PhaseName
  } phase_e;

  typedef enum logic [3:0] {
    ProgNone,
    ProgB,
    ProgD,
    ProgDi,
    ProgL,
    ProgT,
    ProgH
  } prog_e;

  logic          inside_q, inside_d;
  phase_e        phase_q, phase_d;
  prog_e         prog_q, prog_d;
  mts_pkg::byte_t held_q [mts_pkg::HeldDepth];
  mts_pkg::byte_t held_d [mts_pkg::HeldDepth];
  logic [2:0]    cnt_q, cnt_d;
  logic          pend_q, pend_d;
  mts_pkg::byte_t lastb_q, lastb_d;
  logic          ne_q, ne_d;

  mts_pkg::byte_t res [8];
  logic [2:0]    n;
  logic          accept;

  function automatic logic is_ws(input mts_pkg::byte_t c);
    return c == mts_pkg::ChSp || c == mts_pkg::ChTab || c == mts_pkg::ChLf ||
           c == mts_pkg::ChVt || c == mts_pkg::ChFf || c == mts_pkg::ChCr;
  endfunction

  function automatic mts_pkg::byte_t lower(input mts_pkg::byte_t c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;

  // per-byte classification and result packing
  always_comb begin
    mts_pkg::byte_t c, lc, lb, val;
    mts_pkg::byte_t seq [mts_pkg::EntMaxLen];
    logic [8*mts_pkg::EntMaxLen-1:0] txt;
    logic ne, do_plain, hit, skip, ok, full_hit, prefix_any;
    logic [2:0] len;
    prog_e nxt;

    c = in_byte_i;
    lc = lower(c);
    lb = lastb_q;
    ne = ne_q;
    val = '0;
    do_plain = 1'b0;
    hit = 1'b0;
    skip = 1'b0;
    ok = 1'b0;
    full_hit = 1'b0;
    prefix_any = 1'b0;
    len = cnt_q + 3'd1;
    nxt = ProgNone;
    txt = '0;
    n = '0;
    for (int i = 0; i < 8; i++) res[i] = '0;

    inside_d = inside_q;
    phase_d  = phase_q;
    prog_d   = prog_q;
    held_d   = held_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    lastb_d  = lastb_q;
    ne_d     = ne_q;

    // sequence seen so far after '&' plus the new byte
    for (int i = 0; i < mts_pkg::HeldDepth; i++) begin
      seq[i] = (i < cnt_q) ? held_q[i] : c;
    end
    seq[mts_pkg::EntMaxLen-1] = c;

    if (inside_q) begin
      // tag body: only the name start is of interest
      if (c == mts_pkg::ChGt) begin
        inside_d = 1'b0;
        phase_d  = PhaseIdle;
        prog_d   = ProgNone;
      end else if (phase_q != PhaseIdle) begin
        if (phase_q == PhaseSkip) begin
          if (c == mts_pkg::ChSlash || is_ws(c)) begin
            skip = 1'b1;
          end else begin
            case (lc)
              "p":     hit = 1'b1;
              "b":     nxt = ProgB;
              "d":     nxt = ProgD;
              "l":     nxt = ProgL;
              "t":     nxt = ProgT;
              "h":     nxt = ProgH;
              default: nxt = ProgNone;
            endcase
          end
        end else begin
          case (prog_q)
            ProgB:   hit = (lc == "r");
            ProgD:   nxt = (lc == "i") ? ProgDi : ProgNone;
            ProgDi:  hit = (lc == "v");
            ProgL:   hit = (lc == "i");
            ProgT:   hit = (lc == "r");
            ProgH:   hit = (c >= "1" && c <= "4");
            default: hit = 1'b0;
          endcase
        end
        if (!skip) begin
          if (hit && ne_q && lastb_q != mts_pkg::ChLf) begin
            res[n] = mts_pkg::ChLf;
            n = n + 3'd1;
          end
          if (nxt != ProgNone) begin
            phase_d = PhaseName;
            prog_d  = nxt;
          end else begin
            phase_d = PhaseIdle;
            prog_d  = ProgNone;
          end
        end
      end
    end else if (pend_q) begin
      // entity match against all names at once
      for (int k = 0; k < mts_pkg::NumEntities; k++) begin
        txt = mts_pkg::ent_text(k);
        ok = (len <= mts_pkg::ent_len(k));
        for (int i = 0; i < mts_pkg::EntMaxLen; i++) begin
          if (i < len && seq[i] != txt[8*mts_pkg::EntMaxLen-1-8*i -: 8]) ok = 1'b0;
        end
        if (ok) begin
          if (len == mts_pkg::ent_len(k)) begin
            if (!full_hit) val = mts_pkg::ent_value(k);
            full_hit = 1'b1;
          end else begin
            prefix_any = 1'b1;
          end
        end
      end
      if (full_hit) begin
        pend_d = 1'b0;
        cnt_d  = '0;
        res[n] = val;
        n = n + 3'd1;
      end else if (prefix_any && len <= 3'(mts_pkg::HeldDepth)) begin
        held_d[cnt_q[1:0]] = c;
        cnt_d = len;
      end else begin
        // mismatch: replay '&' and held bytes, then treat byte as plain
        res[n] = mts_pkg::ChAmp;
        n = n + 3'd1;
        for (int i = 0; i < mts_pkg::HeldDepth; i++) begin
          if (i < cnt_q) begin
            res[n] = held_q[i];
            n = n + 3'd1;
          end
        end
        pend_d = 1'b0;
        cnt_d  = '0;
        do_plain = 1'b1;
        lb = (cnt_q == 3'd0) ? mts_pkg::ChAmp : held_q[cnt_q[1:0] - 2'd1];
        ne = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    // ordinary text byte
    if (do_plain) begin
      if (c == mts_pkg::ChLt) begin
        inside_d = 1'b1;
        phase_d  = PhaseSkip;
        prog_d   = ProgNone;
      end else if (c == mts_pkg::ChAmp) begin
        pend_d = 1'b1;
        cnt_d  = '0;
      end else if (c == mts_pkg::ChCr) begin
        n = n;
      end else if (c == mts_pkg::ChLf) begin
        if (ne && lb != mts_pkg::ChLf) begin
          res[n] = mts_pkg::ChLf;
          n = n + 3'd1;
        end
      end else if (is_ws(c)) begin
        if (ne && lb != mts_pkg::ChSp && lb != mts_pkg::ChLf) begin
          res[n] = mts_pkg::ChSp;
          n = n + 3'd1;
        end
      end else begin
        res[n] = c;
        n = n + 3'd1;
      end
    end

    // end of text: flush a pending entity and return to reset state
    if (end_of_text_i) begin
      if (pend_d) begin
        res[n] = mts_pkg::ChAmp;
        n = n + 3'd1;
        for (int i = 0; i < mts_pkg::HeldDepth; i++) begin
          if (i < cnt_d) begin
            res[n] = held_d[i];
            n = n + 3'd1;
          end
        end
      end
      inside_d = 1'b0;
      phase_d  = PhaseIdle;
      prog_d   = ProgNone;
      cnt_d    = '0;
      pend_d   = 1'b0;
      lastb_d  = '0;
      ne_d     = 1'b0;
    end else if (n != 3'd0) begin
      lastb_d = res[n - 3'd1];
      ne_d    = 1'b1;
    end
  end

  // request toward the back end
  always_comb begin
    for (int i = 0; i < mts_pkg::MaxResults; i++) job_o.chars[i] = res[i];
    job_o.count = n;
    job_o.eot   = end_of_text_i;
  end

  assign job_push_o = accept && (n != 3'd0 || end_of_text_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      phase_q  <= PhaseIdle;
      prog_q   <= ProgNone;
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      lastb_q  <= '0;
      ne_q     <= 1'b0;
    end else if (accept) begin
      inside_q <= inside_d;
      phase_q  <= phase_d;
      prog_q   <= prog_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      lastb_q  <= lastb_d;
      ne_q     <= ne_d;
    end
  end

  // held entity bytes, valid only below the held count
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

@@ rtl/mts_job_fifo.sv @@
// Short request queue between the front and back ends of the stripper.
// Holds mts_pkg::job_t entries; uses mts_pkg.
module mts_job_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mts_pkg::job_t wdata_i,
  input  logic          pop_i,
  output mts_pkg::job_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mts_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/mts_back.sv @@
// Back end: walks the head request into the output register one result byte
// per cycle while the output is empty or pop_i takes it. Uses mts_pkg.
module mts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mts_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_char_o,
  output logic          char_valid_o,
  output logic          last_o
);

  logic [2:0] pos_q;
  logic       vld_q;
  logic [7:0] char_q;
  logic       cv_q, last_q;
  logic       load, elem_last, bare;

  assign bare      = (job_i.count == 3'd0);
  assign elem_last = bare || (pos_q == job_i.count - 3'd1);
  assign load      = job_valid_i && (!vld_q || pop_i);
  assign job_pop_o = load && elem_last;

  // position in request and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        pos_q <= elem_last ? 3'd0 : pos_q + 3'd1;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= bare ? 8'h00 : job_i.chars[pos_q];
      cv_q   <= !bare;
      last_q <= job_i.eot && elem_last;
    end
  end

  assign empty_o      = !vld_q;
  assign out_char_o   = char_q;
  assign char_valid_o = cv_q;
  assign last_o       = last_q;

endmodule

@@ rtl/markup_text_stripper_unit.sv @@
// Top level of the markup text stripper: front end, request queue, back end.
// Uses mts_pkg, mts_front, mts_job_fifo and mts_back.
//
// Usage:
//   Input side is a queue: drive in_byte_i/end_of_text_i with push_i high;
//   the byte is taken at a clock edge where full_o is low. Set end_of_text_i
//   on the last byte of a text; the next byte starts a fresh text.
//   Result side is a queue: while empty_o is low, out_char_o, char_valid_o
//   and last_o show the oldest result; pop_i takes it at a clock edge.
//   A text whose last byte gives nothing ends with a bare marker
//   (char_valid_o low, last_o high).
// Timing:
//   A result passes through the request queue and the output register.
//   The front takes one byte per cycle while full_o is low; the back
//   delivers one result per cycle while pop_i takes them. A byte gives up
//   to six results (on an entity replay); JobDepth requests absorb such bursts.
// Reset and stall:
//   Reset empties the queue and output register and clears all text state.
//   When pop_i stays low the result holds, the queue fills and full_o rises.
module markup_text_stripper_unit #(
  parameter int JobDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_char_o,
  output logic       char_valid_o,
  output logic       last_o
);

  mts_pkg::job_t job_in, job_head;
  logic job_push, job_pop, job_full, job_empty;

  // classify bytes
  mts_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .full_o        (full_o),
    .job_full_i    (job_full),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  // decouple front and back
  mts_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .rdata_o (job_head),
    .full_o  (job_full),
    .empty_o (job_empty)
  );

  // emit results
  mts_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_head),
    .job_valid_i  (!job_empty),
    .job_pop_o    (job_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .out_char_o   (out_char_o),
    .char_valid_o (char_valid_o),
    .last_o       (last_o)
  );

  // no request pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_push |-> !job_full)
    else $error("request pushed into full queue");

  // a request carries at most six bytes, and an empty one marks end of text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> (job_in.count <= 3'd6 && (job_in.count != 3'd0 || job_in.eot)))
    else $error("malformed request");

  // back end only retires a request that is present
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> !job_empty)
    else $error("request retired from empty queue");

endmodule
